// ===== rtl/dplst_pkg.sv =====
`default_nettype none
package dplst_pkg;

  // phase codes
  localparam logic [3:0] PH_BEGIN    = 4'd0;
  localparam logic [3:0] PH_IDLER    = 4'd1;
  localparam logic [3:0] PH_SELECTOR = 4'd2;
  localparam logic [3:0] PH_PULLEY   = 4'd3;
  localparam logic [3:0] PH_EXEC     = 4'd4;
  localparam logic [3:0] PH_DISPLAY  = 4'd5;
  localparam logic [3:0] PH_CLEANUP  = 4'd6;
  localparam logic [3:0] PH_PASSED   = 4'd7;
  localparam logic [3:0] PH_FAILED   = 4'd8;

  // error kinds
  localparam logic [1:0] ERR_RUNNING = 2'd0;
  localparam logic [1:0] ERR_OK      = 2'd1;
  localparam logic [1:0] ERR_PINS    = 2'd2;

  // axes
  localparam logic [1:0] AXIS_IDLER    = 2'd0;
  localparam logic [1:0] AXIS_SELECTOR = 2'd1;
  localparam logic [1:0] AXIS_PULLEY   = 2'd2;

  // mode codes
  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_STEP    = 1'b1;

  // configuration register indexes
  localparam logic CFG_HOLD_MS    = 1'b0;
  localparam logic CFG_PASS_COUNT = 1'b1;

  localparam logic [7:0] HOLD_MS_RST    = 8'd50;
  localparam logic [4:0] PASS_COUNT_RST = 5'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] now_ms;
    logic        rb_step;
    logic        rb_dir;
    logic        rb_enable_n;
  } in_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       finished;
    logic [1:0] error_kind;
    logic [2:0] failed_axes;
    logic [2:0] fault_idler;
    logic [2:0] fault_selector;
    logic [2:0] fault_pulley;
    logic [2:0] last_bit_errors;
    logic [1:0] test_axis;
    logic [2:0] drive_pattern;
    logic       heartbeat;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/dplst_seq.sv =====
`default_nettype none
module dplst_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_index_i,
  input  wire logic [7:0]      cfg_data_i,
  input  wire logic            in_acc_i,
  input  wire dplst_pkg::in_t  in_data_i,
  output dplst_pkg::out_t      res_o
);

  logic [7:0]  hold_ms_q;
  logic [4:0]  pass_count_q;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  after_q, after_d;
  logic [1:0]  axis_q, axis_d;
  logic [7:0]  pattern_q, pattern_d;
  logic [2:0]  fault_q [3];
  logic [2:0]  fault_d [3];
  logic [15:0] hold_start_q, hold_start_d;
  logic        heartbeat_q, heartbeat_d;
  logic [1:0]  error_q, error_d;

  logic [2:0]  rb;
  logic [2:0]  errs;
  logic [15:0] elapsed;
  logic        hold_over;
  logic        exec_now;
  logic [7:0]  limit;
  logic [1:0]  ax_idx;
  logic [2:0]  any_fault;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q    <= dplst_pkg::HOLD_MS_RST;
      pass_count_q <= dplst_pkg::PASS_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == dplst_pkg::CFG_HOLD_MS) begin
        hold_ms_q <= cfg_data_i;
      end else begin
        pass_count_q <= cfg_data_i[4:0];
      end
    end
  end

  assign rb        = {~in_data_i.rb_enable_n, in_data_i.rb_dir, in_data_i.rb_step};
  assign elapsed   = in_data_i.now_ms - hold_start_q;
  assign hold_over = elapsed > {8'd0, hold_ms_q};
  assign limit     = {pass_count_q, 3'b000};
  // axis code three never occurs; it maps onto the idler like a mod 3
  assign ax_idx    = (axis_q == 2'd3) ? dplst_pkg::AXIS_IDLER : axis_q;
  assign exec_now  = (phase_q == dplst_pkg::PH_EXEC) ||
                     ((phase_q == dplst_pkg::PH_DISPLAY) && hold_over);

  always_comb begin
    phase_d      = phase_q;
    after_d      = after_q;
    axis_d       = axis_q;
    pattern_d    = pattern_q;
    fault_d      = fault_q;
    hold_start_d = hold_start_q;
    heartbeat_d  = heartbeat_q;
    error_d      = error_q;
    errs         = 3'd0;
    if (in_acc_i) begin
      if (in_data_i.mode == dplst_pkg::MODE_RESTART) begin
        phase_d    = dplst_pkg::PH_BEGIN;
        error_d    = dplst_pkg::ERR_RUNNING;
        axis_d     = dplst_pkg::AXIS_IDLER;
        fault_d[0] = 3'd0;
        fault_d[1] = 3'd0;
        fault_d[2] = 3'd0;
      end else begin
        case (phase_q)
          dplst_pkg::PH_BEGIN: begin
            pattern_d = 8'd0;
            phase_d   = dplst_pkg::PH_IDLER;
          end
          dplst_pkg::PH_IDLER: begin
            axis_d  = dplst_pkg::AXIS_IDLER;
            phase_d = dplst_pkg::PH_EXEC;
            after_d = dplst_pkg::PH_SELECTOR;
          end
          dplst_pkg::PH_SELECTOR: begin
            axis_d  = dplst_pkg::AXIS_SELECTOR;
            phase_d = dplst_pkg::PH_EXEC;
            after_d = dplst_pkg::PH_PULLEY;
          end
          dplst_pkg::PH_PULLEY: begin
            axis_d  = dplst_pkg::AXIS_PULLEY;
            phase_d = dplst_pkg::PH_EXEC;
            after_d = dplst_pkg::PH_CLEANUP;
          end
          dplst_pkg::PH_CLEANUP: begin
            if ((fault_q[0] | fault_q[1] | fault_q[2]) != 3'd0) begin
              phase_d = dplst_pkg::PH_FAILED;
              error_d = dplst_pkg::ERR_PINS;
            end else begin
              phase_d = dplst_pkg::PH_PASSED;
              error_d = dplst_pkg::ERR_OK;
            end
          end
          default: begin
          end
        endcase
        if (exec_now) begin
          if (pattern_q < limit) begin
            errs                = rb ^ pattern_q[2:0];
            fault_d[ax_idx]     = fault_q[ax_idx] | errs;
            hold_start_d        = in_data_i.now_ms;
            heartbeat_d         = ~heartbeat_q;
            phase_d             = dplst_pkg::PH_DISPLAY;
            pattern_d           = pattern_q + 8'd1;
          end else begin
            pattern_d = 8'd0;
            phase_d   = after_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= dplst_pkg::PH_BEGIN;
      after_q      <= dplst_pkg::PH_BEGIN;
      axis_q       <= dplst_pkg::AXIS_IDLER;
      pattern_q    <= 8'd0;
      fault_q[0]   <= 3'd0;
      fault_q[1]   <= 3'd0;
      fault_q[2]   <= 3'd0;
      hold_start_q <= 16'd0;
      heartbeat_q  <= 1'b0;
      error_q      <= dplst_pkg::ERR_RUNNING;
    end else begin
      phase_q      <= phase_d;
      after_q      <= after_d;
      axis_q       <= axis_d;
      pattern_q    <= pattern_d;
      fault_q      <= fault_d;
      hold_start_q <= hold_start_d;
      heartbeat_q  <= heartbeat_d;
      error_q      <= error_d;
    end
  end

  assign any_fault = {fault_d[2] != 3'd0, fault_d[1] != 3'd0, fault_d[0] != 3'd0};

  always_comb begin
    res_o                 = '0;
    res_o.phase           = phase_d;
    res_o.finished        = phase_d >= dplst_pkg::PH_PASSED;
    res_o.error_kind      = error_d;
    res_o.failed_axes     = (phase_d >= dplst_pkg::PH_FAILED) ? any_fault : 3'd0;
    res_o.fault_idler     = fault_d[0];
    res_o.fault_selector  = fault_d[1];
    res_o.fault_pulley    = fault_d[2];
    res_o.last_bit_errors = errs;
    res_o.test_axis       = axis_d;
    res_o.drive_pattern   = pattern_d[2:0];
    res_o.heartbeat       = heartbeat_d;
  end

`ifndef ASSERT_OFF
  a_failed_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dplst_pkg::PH_FAILED |-> error_q == dplst_pkg::ERR_PINS)
    else $error("failed phase without pins error");
  a_passed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dplst_pkg::PH_PASSED |->
      (fault_q[0] == 3'd0 && fault_q[1] == 3'd0 && fault_q[2] == 3'd0))
    else $error("passed with faults recorded");
  a_hb_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc_i |=> $stable(heartbeat_q))
    else $error("heartbeat moved without a beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/dplst_outbuf.sv =====
`default_nettype none
module dplst_outbuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire dplst_pkg::out_t  push_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dplst_pkg::out_t       out_data_o
);

  dplst_pkg::out_t main_q;
  dplst_pkg::out_t skid_q;
  logic            main_valid_q;
  logic            skid_valid_q;
  logic            push;
  logic            pop;

  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = main_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_valid_q && !pop) begin
      // main beat stalled, park a new one in the skid slot
      if (push) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      main_valid_q <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_valid_q && !pop) begin
      if (push) begin
        skid_q <= push_data_i;
      end
    end else if (skid_valid_q) begin
      main_q <= skid_q;
    end else if (push) begin
      main_q <= push_data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

`ifndef ASSERT_OFF
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot full while main slot empty");
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("skid beat lost while stalled");
  a_skid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (main_valid_q && !skid_valid_q))
    else $error("skid beat not moved to main slot");
`endif

endmodule
`default_nettype wire

// ===== rtl/driver_pin_loopback_self_test_core.sv =====
// result: built combinationally from the input beat, then registered in the output buffer
// throughput: one input beat per cycle while the skid slot is empty; the state update is a single
// combinational step from the state registers into the output register
// a two-entry output buffer keeps input open while one result waits
// reset: asynchronous active low; sequencer back to begin, faults cleared,
// hold 50 ms, three passes, output buffer empty
`default_nettype none
module driver_pin_loopback_self_test_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dplst_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dplst_pkg::out_t       out_data_o
);

  dplst_pkg::out_t res;
  logic            in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  dplst_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_acc_i    (in_acc),
    .in_data_i   (in_data_i),
    .res_o       (res)
  );

  dplst_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;

  localparam int STALL_LIMIT = 1000;

  typedef struct {
    bit                   is_cfg;
    logic                 cfg_idx;
    logic [7:0]           cfg_val;
    dplst_pkg::in_t       beat;
    bit                   typed;
    dplst_pkg::out_t      want;
  } script_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_index_i = dplst_pkg::CFG_HOLD_MS;
  logic [7:0]      cfg_data_i = 8'd0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  dplst_pkg::in_t  in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  dplst_pkg::out_t out_data_o;

  always #1 clk_i = ~clk_i;

  driver_pin_loopback_self_test_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // sequencer prediction state
  logic [7:0]  hold_cfg = dplst_pkg::HOLD_MS_RST;
  logic [4:0]  passes_cfg = dplst_pkg::PASS_COUNT_RST;
  logic [3:0]  seq_phase = dplst_pkg::PH_BEGIN;
  logic [3:0]  resume_phase = dplst_pkg::PH_BEGIN;
  logic [1:0]  cur_axis = dplst_pkg::AXIS_IDLER;
  logic [7:0]  pat_count = 8'd0;
  logic [2:0]  axis_faults [3];
  logic [15:0] hold_from = 16'd0;
  logic        beat_flag = 1'b0;
  logic [1:0]  verdict = dplst_pkg::ERR_RUNNING;

  dplst_pkg::out_t pending_q [$];
  script_row_t     script [$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          tests_passed = 0;
  int          tests_failed = 0;
  int          in_quiet = 0;
  int          out_quiet = 0;
  int          idle_cycles = 0;
  bit          clean_run = 1'b1;
  logic [15:0] last_stamp = 16'd0;

  task automatic report_mismatch(input string what);
    begin
      mismatches++;
      $display("mismatch: %s", what);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    begin
      if (got != want)
        report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                  results_seen, name, got, want));
    end
  endtask

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet = $urandom_range(8, 40);
    return $urandom_range(0, 18);
  endfunction

  // one comparison, or the end of the axis once all patterns are done
  task automatic apply_pattern(input logic [15:0] stamp, input logic [2:0] readback,
                               output logic [2:0] mismatch);
    begin
      mismatch = 3'b000;
      if (int'(pat_count) < int'(passes_cfg) * 8) begin
        mismatch = readback ^ pat_count[2:0];
        axis_faults[cur_axis] = axis_faults[cur_axis] | mismatch;
        hold_from = stamp;
        beat_flag = ~beat_flag;
        seq_phase = dplst_pkg::PH_DISPLAY;
        pat_count = pat_count + 8'd1;
      end else begin
        pat_count = 8'd0;
        seq_phase = resume_phase;
      end
    end
  endtask

  task automatic advance_sequencer(input dplst_pkg::in_t beat, output dplst_pkg::out_t res);
    logic [2:0]  readback;
    logic [2:0]  mismatch;
    logic [15:0] elapsed;
    begin
      // enable readback is active low, compared as active high
      readback = {~beat.rb_enable_n, beat.rb_dir, beat.rb_step};
      mismatch = 3'b000;
      if (beat.mode == dplst_pkg::MODE_RESTART) begin
        seq_phase = dplst_pkg::PH_BEGIN;
        verdict = dplst_pkg::ERR_RUNNING;
        cur_axis = dplst_pkg::AXIS_IDLER;
        axis_faults[0] = 3'b000;
        axis_faults[1] = 3'b000;
        axis_faults[2] = 3'b000;
      end else begin
        case (seq_phase)
          dplst_pkg::PH_BEGIN: begin
            pat_count = 8'd0;
            seq_phase = dplst_pkg::PH_IDLER;
          end
          dplst_pkg::PH_IDLER: begin
            cur_axis = dplst_pkg::AXIS_IDLER;
            seq_phase = dplst_pkg::PH_EXEC;
            resume_phase = dplst_pkg::PH_SELECTOR;
          end
          dplst_pkg::PH_SELECTOR: begin
            cur_axis = dplst_pkg::AXIS_SELECTOR;
            seq_phase = dplst_pkg::PH_EXEC;
            resume_phase = dplst_pkg::PH_PULLEY;
          end
          dplst_pkg::PH_PULLEY: begin
            cur_axis = dplst_pkg::AXIS_PULLEY;
            seq_phase = dplst_pkg::PH_EXEC;
            resume_phase = dplst_pkg::PH_CLEANUP;
          end
          dplst_pkg::PH_DISPLAY: begin
            elapsed = beat.now_ms - hold_from;
            if (elapsed > {8'd0, hold_cfg}) apply_pattern(beat.now_ms, readback, mismatch);
          end
          dplst_pkg::PH_EXEC: begin
            apply_pattern(beat.now_ms, readback, mismatch);
          end
          dplst_pkg::PH_CLEANUP: begin
            if ((axis_faults[0] | axis_faults[1] | axis_faults[2]) != 3'b000) begin
              seq_phase = dplst_pkg::PH_FAILED;
              verdict = dplst_pkg::ERR_PINS;
              tests_failed++;
            end else begin
              seq_phase = dplst_pkg::PH_PASSED;
              verdict = dplst_pkg::ERR_OK;
              tests_passed++;
            end
          end
          default: begin
          end
        endcase
      end
      res = '0;
      res.phase = seq_phase;
      res.finished = (seq_phase >= dplst_pkg::PH_PASSED);
      res.error_kind = verdict;
      if (seq_phase >= dplst_pkg::PH_FAILED)
        res.failed_axes = {|axis_faults[2], |axis_faults[1], |axis_faults[0]};
      res.fault_idler = axis_faults[0];
      res.fault_selector = axis_faults[1];
      res.fault_pulley = axis_faults[2];
      res.last_bit_errors = mismatch;
      res.test_axis = cur_axis;
      res.drive_pattern = pat_count[2:0];
      res.heartbeat = beat_flag;
    end
  endtask

  task automatic push_step(input logic mode, input logic [15:0] stamp, input logic st,
                           input logic dr, input logic en_n, input bit typed,
                           input logic [3:0] typed_phase);
    script_row_t row;
    begin
      row.is_cfg = 1'b0;
      row.cfg_idx = dplst_pkg::CFG_HOLD_MS;
      row.cfg_val = 8'd0;
      row.beat = '0;
      row.beat.mode = mode;
      row.beat.now_ms = stamp;
      row.beat.rb_step = st;
      row.beat.rb_dir = dr;
      row.beat.rb_enable_n = en_n;
      row.typed = typed;
      // typed rows only come right after reset, where all but the phase is zero
      row.want = '0;
      row.want.phase = typed_phase;
      script.push_back(row);
    end
  endtask

  task automatic push_cfg(input logic idx, input logic [7:0] val);
    script_row_t row;
    begin
      row.is_cfg = 1'b1;
      row.cfg_idx = idx;
      row.cfg_val = val;
      row.beat = '0;
      row.typed = 1'b0;
      row.want = '0;
      script.push_back(row);
    end
  endtask

  // caller has no in_valid_i assignment pending in this step
  task automatic program_register(input logic idx, input logic [7:0] val, input bit last);
    begin
      in_valid_i <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx == dplst_pkg::CFG_HOLD_MS) hold_cfg = val;
      else passes_cfg = val[4:0];
      reg_writes++;
      if (last) cfg_valid_i <= 1'b0;
    end
  endtask

  // returns in the step the beat is accepted, valid left as it is
  task automatic send_beat(input dplst_pkg::in_t beat, input bit typed,
                           input dplst_pkg::out_t want);
    int              gap;
    dplst_pkg::out_t predicted;
    begin
      gap = draw_wait(in_quiet);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i <= beat;
      do @(posedge clk_i); while (!in_ready_o);
      advance_sequencer(beat, predicted);
      pending_q.push_back(typed ? want : predicted);
      beats_sent++;
    end
  endtask

  // mostly well-formed step calls that follow the predicted pattern and hold
  task automatic make_random_beat(output dplst_pkg::in_t beat);
    int          r;
    int          t;
    int          pick;
    logic [2:0]  rb_bits;
    logic [15:0] stamp;
    begin
      beat = '0;
      beat.mode = dplst_pkg::MODE_STEP;
      if (seq_phase >= dplst_pkg::PH_PASSED) begin
        if ($urandom_range(0, 1) == 1) beat.mode = dplst_pkg::MODE_RESTART;
      end else if ($urandom_range(0, 59) == 0) begin
        beat.mode = dplst_pkg::MODE_RESTART;
      end
      if (beat.mode == dplst_pkg::MODE_RESTART) begin
        r = $urandom_range(0, 1);
        clean_run = r[0];
      end

      pick = $urandom_range(0, 99);
      if (seq_phase == dplst_pkg::PH_DISPLAY && pick < 70) begin
        t = int'(hold_from) + int'(hold_cfg) + 1 + $urandom_range(0, 5);
      end else if (seq_phase == dplst_pkg::PH_DISPLAY && pick < 80) begin
        t = int'(hold_from) + int'(hold_cfg);
      end else if (seq_phase == dplst_pkg::PH_DISPLAY && pick < 90) begin
        t = int'(hold_from) + $urandom_range(0, hold_cfg);
      end else if (seq_phase != dplst_pkg::PH_DISPLAY && pick < 95) begin
        t = int'(last_stamp) + $urandom_range(0, 3);
      end else begin
        t = $urandom;
      end
      stamp = t[15:0];
      last_stamp = stamp;
      beat.now_ms = stamp;

      rb_bits = pat_count[2:0];
      if (!clean_run && $urandom_range(0, 9) == 0) begin
        r = $urandom_range(1, 7);
        rb_bits = rb_bits ^ r[2:0];
      end
      if (seq_phase != dplst_pkg::PH_EXEC && seq_phase != dplst_pkg::PH_DISPLAY &&
          $urandom_range(0, 3) == 0) begin
        r = $urandom;
        rb_bits = r[2:0];
      end
      beat.rb_step = rb_bits[0];
      beat.rb_dir = rb_bits[1];
      beat.rb_enable_n = ~rb_bits[2];
    end
  endtask

  initial begin : stimulus
    dplst_pkg::in_t beat;
    logic [7:0]     hold_plan [8];
    logic [4:0]     pass_plan [8];
    int             span_plan [8];

    axis_faults[0] = 3'b000;
    axis_faults[1] = 3'b000;
    axis_faults[2] = 3'b000;

    // first beats after reset, then a wrapped hold that ends one ms past the limit
    push_step(dplst_pkg::MODE_STEP, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, dplst_pkg::PH_IDLER);
    push_step(dplst_pkg::MODE_STEP, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, dplst_pkg::PH_EXEC);
    push_step(dplst_pkg::MODE_STEP, 16'hFFF0, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0022, 1'b1, 1'b1, 1'b0, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0023, 1'b1, 1'b1, 1'b0, 1'b0, dplst_pkg::PH_BEGIN);
    // no passes and no hold: rest of the test runs out and fails on the idler fault
    push_cfg(dplst_pkg::CFG_PASS_COUNT, 8'd0);
    push_cfg(dplst_pkg::CFG_HOLD_MS, 8'd0);
    push_step(dplst_pkg::MODE_STEP, 16'h0024, 1'b1, 1'b0, 1'b0, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0024, 1'b0, 1'b1, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0024, 1'b1, 1'b1, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0024, 1'b0, 1'b0, 1'b0, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0024, 1'b1, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0024, 1'b0, 1'b1, 1'b0, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'h0024, 1'b1, 1'b1, 1'b0, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_RESTART, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    // one pass, zero hold, then the pass count drops under the running count
    push_cfg(dplst_pkg::CFG_PASS_COUNT, 8'd1);
    push_step(dplst_pkg::MODE_STEP, 16'd200, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd200, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd200, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd200, 1'b1, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd201, 1'b1, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_cfg(dplst_pkg::CFG_PASS_COUNT, 8'd0);
    push_step(dplst_pkg::MODE_STEP, 16'd202, 1'b0, 1'b1, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd202, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd202, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd202, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd202, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);
    push_step(dplst_pkg::MODE_STEP, 16'd202, 1'b0, 1'b0, 1'b1, 1'b0, dplst_pkg::PH_BEGIN);

    hold_plan[0] = dplst_pkg::HOLD_MS_RST;
    pass_plan[0] = dplst_pkg::PASS_COUNT_RST;
    span_plan[0] = 200;
    hold_plan[1] = 8'd255;      pass_plan[1] = 5'd1;           span_plan[1] = 150;
    hold_plan[2] = 8'd1;        pass_plan[2] = 5'd31;          span_plan[2] = 250;
    hold_plan[3] = 8'd0;        pass_plan[3] = 5'd2;           span_plan[3] = 150;
    for (int p = 4; p < 8; p++) begin
      hold_plan[p] = 8'($urandom_range(1, 255));
      pass_plan[p] = 5'($urandom_range(1, 4));
      span_plan[p] = 175;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < script.size(); i++) begin
      if (script[i].is_cfg) begin
        program_register(script[i].cfg_idx, script[i].cfg_val,
                         (i + 1 >= script.size()) || !script[i + 1].is_cfg);
      end else begin
        send_beat(script[i].beat, script[i].typed, script[i].want);
      end
    end

    // settings change mid-test too, since nothing restarts at a phase boundary
    for (int p = 0; p < 8; p++) begin
      program_register(dplst_pkg::CFG_HOLD_MS, hold_plan[p], 1'b0);
      program_register(dplst_pkg::CFG_PASS_COUNT, {3'b000, pass_plan[p]}, 1'b1);
      for (int k = 0; k < span_plan[p]; k++) begin
        make_random_beat(beat);
        send_beat(beat, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("sent %0d input beats, checked %0d result beats, %0d register writes",
             beats_sent, results_seen, reg_writes);
    $display("tests run to a verdict: %0d passed, %0d failed; %0d mismatches",
             tests_passed, tests_failed, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_side
    dplst_pkg::out_t got;
    dplst_pkg::out_t want;
    int              stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(out_quiet);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = out_data_o;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_q.pop_front();
        check_field("phase", int'(got.phase), int'(want.phase));
        check_field("finished", int'(got.finished), int'(want.finished));
        check_field("error_kind", int'(got.error_kind), int'(want.error_kind));
        check_field("failed_axes", int'(got.failed_axes), int'(want.failed_axes));
        check_field("fault_idler", int'(got.fault_idler), int'(want.fault_idler));
        check_field("fault_selector", int'(got.fault_selector), int'(want.fault_selector));
        check_field("fault_pulley", int'(got.fault_pulley), int'(want.fault_pulley));
        check_field("last_bit_errors", int'(got.last_bit_errors),
                    int'(want.last_bit_errors));
        check_field("test_axis", int'(got.test_axis), int'(want.test_axis));
        check_field("drive_pattern", int'(got.drive_pattern), int'(want.drive_pattern));
        check_field("heartbeat", int'(got.heartbeat), int'(want.heartbeat));
      end
    end
  end

  // no beat on any channel for too long means the block is stuck
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/dplst_pkg.sv
rtl/dplst_seq.sv
rtl/dplst_outbuf.sv
rtl/driver_pin_loopback_self_test_core.sv
tb/testbench.sv
